[rtl/multirotor_position_height_controller_macros.svh]
// Assertion macros for the checker module.
`ifndef MULTIROTOR_POSITION_HEIGHT_CONTROLLER_MACROS_SVH
`define MULTIROTOR_POSITION_HEIGHT_CONTROLLER_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define MPHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset
`define MPHC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/mphc_pkg.sv]
package mphc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_GAIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_TARGET = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_P_GAIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_I_GAIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_D_GAIN = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRUST_BASE   = 3'd6;

    // Fixed-point constants
    localparam logic signed [15:0] STICK_BAND     = 16'sd6553;   // 0.2 in Q1.15
    localparam logic signed [32:0] SETPOINT_STEP  = 33'sd328;    // 0.005 m in Q16.16
    localparam logic signed [12:0] ANGLE_LIMIT    = 13'sd2703;   // 0.33 rad in Q3.13
    localparam logic signed [11:0] INTEGRAL_LIMIT = 12'sd1638;   // 0.05 in Q1.15
    localparam logic [14:0]        THRUST_FLOOR   = 15'd16384;   // 0.5 in Q1.15

    // One position update as held in the input stage
    typedef struct packed {
        logic               auto_mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [15:0] stick_pitch;
        logic signed [15:0] stick_roll;
        logic [14:0]        stick_throttle;
        logic               throttle_valid;
        logic signed [15:0] yaw_now;
    } t_item;

endpackage

[rtl/multirotor_position_height_controller.sv]
// Position and height controller for a multirotor, one position update per request.
// Input channel: i_in_valid / o_in_stall with the update fields on their own ports.
// Output channel: o_out_valid / i_out_stall carrying roll, pitch, yaw and thrust.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at the clock edge;
// write only while no request is in flight.
// Throughput: one request per clock while the pipeline is not stalled. The pipeline is
// input register, state update, multiplier rank, result register. Requests in manual
// mode update state but give no result. Stalls: i_out_stall freezes the whole pipeline
// while a result is offered; a one-entry skid buffer takes the request offered in that
// cycle, and o_in_stall (a register) is high while it is full.
// Reset (synchronous, active low): pipeline empty, setpoints, height integral and
// yaw averaging cleared, thrust ceiling at 0.5, all configuration registers zero.
module multirotor_position_height_controller #(
    parameter int YAW_SAMPLES = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [mphc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_auto_mode,
    input  logic signed [31:0]                   i_pos_x,
    input  logic signed [31:0]                   i_pos_y,
    input  logic signed [31:0]                   i_pos_z,
    input  logic signed [31:0]                   i_vel_x,
    input  logic signed [31:0]                   i_vel_y,
    input  logic signed [15:0]                   i_stick_pitch,
    input  logic signed [15:0]                   i_stick_roll,
    input  logic [14:0]                          i_stick_throttle,
    input  logic                                 i_throttle_valid,
    input  logic signed [15:0]                   i_yaw_now,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [12:0]                   o_roll_cmd,
    output logic signed [12:0]                   o_pitch_cmd,
    output logic signed [15:0]                   o_yaw_cmd,
    output logic [14:0]                          o_thrust_cmd
);

    localparam int YawCntW   = $clog2(YAW_SAMPLES + 1);
    localparam int RecipShift = 24;
    localparam longint YawRecip = ((64'd1 << RecipShift) + YAW_SAMPLES - 1) / YAW_SAMPLES;

    // saturate a 33-bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // saturate a 49-bit sum to 48 bits
    function automatic logic signed [47:0] sat49(input logic signed [48:0] v);
        logic signed [47:0] res;
        if (v[48] != v[47]) begin
            res = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

    // clamp an angle sum to +-0.33 rad
    function automatic logic signed [12:0] clamp_angle(input logic signed [45:0] v);
        logic signed [12:0] res;
        if (v > 46'(mphc_pkg::ANGLE_LIMIT)) begin
            res = mphc_pkg::ANGLE_LIMIT;
        end else if (v < -46'(mphc_pkg::ANGLE_LIMIT)) begin
            res = -mphc_pkg::ANGLE_LIMIT;
        end else begin
            res = v[12:0];
        end
        return res;
    endfunction

    // configuration registers
    logic signed [31:0] r_position_gain, r_velocity_gain, r_height_target;
    logic signed [31:0] r_height_p_gain, r_height_i_gain, r_height_d_gain;
    logic [14:0]        r_thrust_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_gain <= '0;
            r_velocity_gain <= '0;
            r_height_target <= '0;
            r_height_p_gain <= '0;
            r_height_i_gain <= '0;
            r_height_d_gain <= '0;
            r_thrust_base   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mphc_pkg::CFG_POSITION_GAIN: r_position_gain <= i_cfg_data;
                mphc_pkg::CFG_VELOCITY_GAIN: r_velocity_gain <= i_cfg_data;
                mphc_pkg::CFG_HEIGHT_TARGET: r_height_target <= i_cfg_data;
                mphc_pkg::CFG_HEIGHT_P_GAIN: r_height_p_gain <= i_cfg_data;
                mphc_pkg::CFG_HEIGHT_I_GAIN: r_height_i_gain <= i_cfg_data;
                mphc_pkg::CFG_HEIGHT_D_GAIN: r_height_d_gain <= i_cfg_data;
                mphc_pkg::CFG_THRUST_BASE:   r_thrust_base   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless a finished result is held up
    logic adv;
    logic r_out_valid;
    assign adv = !(r_out_valid && i_out_stall);

    // input request and skid buffer
    mphc_pkg::t_item in_item;
    mphc_pkg::t_item r_skid_item, r_in_item;
    logic            r_skid_valid, r_in_valid;

    assign in_item = '{
        auto_mode:      i_auto_mode,
        pos_x:          i_pos_x,
        pos_y:          i_pos_y,
        pos_z:          i_pos_z,
        vel_x:          i_vel_x,
        vel_y:          i_vel_y,
        stick_pitch:    i_stick_pitch,
        stick_roll:     i_stick_roll,
        stick_throttle: i_stick_throttle,
        throttle_valid: i_throttle_valid,
        yaw_now:        i_yaw_now
    };
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_in_valid   <= 1'b0;
        end else if (adv) begin
            r_in_valid   <= r_skid_valid || i_in_valid;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid && i_in_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_item <= r_skid_valid ? r_skid_item : in_item;
        end
        if (!adv && !r_skid_valid) begin
            r_skid_item <= in_item;
        end
    end

    // controller state
    logic signed [31:0]        r_target_x, r_target_y, r_prev_height;
    logic signed [47:0]        r_err_sum;
    logic [14:0]               r_ceiling;
    logic signed [19:0]        r_yaw_acc;
    logic [YawCntW-1:0]        r_yaw_cnt;
    logic signed [31:0]        n_target_x, n_target_y, n_prev_height;
    logic signed [47:0]        n_err_sum;
    logic [14:0]               n_ceiling;
    logic signed [19:0]        n_yaw_acc;
    logic [YawCntW-1:0]        n_yaw_cnt;
    logic                      make_held;
    logic signed [31:0]        herr, dz, perr, rerr;

    // stage 1: setpoints, integral, yaw averaging and errors
    assign herr = sat33({r_in_item.pos_z[31], r_in_item.pos_z}
                        - {r_height_target[31], r_height_target});
    assign dz   = sat33({r_prev_height[31], r_prev_height}
                        - {r_in_item.pos_z[31], r_in_item.pos_z});
    assign perr = sat33({r_in_item.pos_x[31], r_in_item.pos_x}
                        - {n_target_x[31], n_target_x});
    assign rerr = sat33({n_target_y[31], n_target_y}
                        - {r_in_item.pos_y[31], r_in_item.pos_y});

    always_comb begin
        n_target_x    = r_target_x;
        n_target_y    = r_target_y;
        n_err_sum     = r_err_sum;
        n_prev_height = r_prev_height;
        n_ceiling     = r_ceiling;
        n_yaw_acc     = r_yaw_acc;
        n_yaw_cnt     = r_yaw_cnt;
        make_held     = 1'b0;
        if (!r_in_item.auto_mode) begin
            n_target_x = '0;
            n_target_y = '0;
            n_yaw_acc  = '0;
            n_yaw_cnt  = '0;
        end else begin
            // yaw averaging over the first samples
            if (r_yaw_cnt < YawCntW'(YAW_SAMPLES)) begin
                n_yaw_acc = r_yaw_acc + {{4{r_in_item.yaw_now[15]}}, r_in_item.yaw_now};
                n_yaw_cnt = r_yaw_cnt + 1'b1;
                make_held = (n_yaw_cnt == YawCntW'(YAW_SAMPLES));
            end
            // stick nudges of the x/y setpoints
            if (r_in_item.stick_pitch < -mphc_pkg::STICK_BAND) begin
                n_target_x = sat33({r_target_x[31], r_target_x} + mphc_pkg::SETPOINT_STEP);
            end else if (r_in_item.stick_pitch > mphc_pkg::STICK_BAND) begin
                n_target_x = sat33({r_target_x[31], r_target_x} - mphc_pkg::SETPOINT_STEP);
            end
            if (r_in_item.stick_roll < -mphc_pkg::STICK_BAND) begin
                n_target_y = sat33({r_target_y[31], r_target_y} - mphc_pkg::SETPOINT_STEP);
            end else if (r_in_item.stick_roll > mphc_pkg::STICK_BAND) begin
                n_target_y = sat33({r_target_y[31], r_target_y} + mphc_pkg::SETPOINT_STEP);
            end
            // height integral and last height
            n_err_sum     = sat49({r_err_sum[47], r_err_sum} + {{17{herr[31]}}, herr});
            n_prev_height = r_in_item.pos_z;
            if (r_in_item.throttle_valid) begin
                n_ceiling = r_in_item.stick_throttle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_err_sum     <= '0;
            r_prev_height <= '0;
            r_ceiling     <= mphc_pkg::THRUST_FLOOR;
            r_yaw_acc     <= '0;
            r_yaw_cnt     <= '0;
        end else if (adv && r_in_valid) begin
            r_target_x    <= n_target_x;
            r_target_y    <= n_target_y;
            r_err_sum     <= n_err_sum;
            r_prev_height <= n_prev_height;
            r_ceiling     <= n_ceiling;
            r_yaw_acc     <= n_yaw_acc;
            r_yaw_cnt     <= n_yaw_cnt;
        end
    end

    // stage 1 register
    logic               r_s1_valid, r_s1_emit, r_s1_make_held, r_s1_use_held;
    logic signed [31:0] r_s1_perr, r_s1_rerr, r_s1_vx, r_s1_vy, r_s1_herr, r_s1_dz;
    logic signed [47:0] r_s1_sum;
    logic [14:0]        r_s1_ceiling;
    logic signed [15:0] r_s1_yaw;
    logic signed [19:0] r_s1_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_emit      <= r_in_item.auto_mode;
            r_s1_make_held <= make_held;
            r_s1_use_held  <= (n_yaw_cnt == YawCntW'(YAW_SAMPLES));
            r_s1_perr      <= perr;
            r_s1_rerr      <= rerr;
            r_s1_vx        <= r_in_item.vel_x;
            r_s1_vy        <= r_in_item.vel_y;
            r_s1_herr      <= herr;
            r_s1_dz        <= dz;
            r_s1_sum       <= n_err_sum;
            r_s1_ceiling   <= n_ceiling;
            r_s1_yaw       <= r_in_item.yaw_now;
            r_s1_acc       <= n_yaw_acc;
        end
    end

    // stage 2: multiplier rank and yaw average by reciprocal
    logic [19:0]        yaw_mag;
    logic [44:0]        yaw_prod;
    logic [16:0]        yaw_quot_mag;
    logic signed [15:0] yaw_quot;
    logic signed [31:0] sum_hi;
    logic signed [16:0] sum_lo;
    logic signed [15:0] r_held_yaw;

    assign yaw_mag      = r_s1_acc[19] ? 20'(-r_s1_acc) : r_s1_acc;
    assign yaw_prod     = yaw_mag * 25'(YawRecip);
    assign yaw_quot_mag = yaw_prod[RecipShift +: 17];
    assign yaw_quot     = r_s1_acc[19] ? 16'(-yaw_quot_mag) : yaw_quot_mag[15:0];
    assign sum_hi       = r_s1_sum[47:16];
    assign sum_lo       = {1'b0, r_s1_sum[15:0]};

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid && r_s1_make_held) begin
            r_held_yaw <= yaw_quot;
        end
    end

    logic               r_s2_valid, r_s2_emit;
    logic signed [63:0] r_s2_pp, r_s2_pv, r_s2_rp, r_s2_rv, r_s2_hp, r_s2_hd, r_s2_p1;
    logic signed [48:0] r_s2_p0;
    logic [14:0]        r_s2_ceiling;
    logic signed [15:0] r_s2_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_emit    <= r_s1_emit;
            r_s2_pp      <= r_s1_perr * r_position_gain;
            r_s2_pv      <= r_s1_vx * r_velocity_gain;
            r_s2_rp      <= r_s1_rerr * r_position_gain;
            r_s2_rv      <= r_s1_vy * r_velocity_gain;
            r_s2_hp      <= r_s1_herr * r_height_p_gain;
            r_s2_hd      <= r_s1_dz * r_height_d_gain;
            r_s2_p1      <= sum_hi * r_height_i_gain;
            r_s2_p0      <= sum_lo * r_height_i_gain;
            r_s2_ceiling <= r_s1_ceiling;
            if (r_s1_make_held) begin
                r_s2_yaw <= yaw_quot;
            end else if (r_s1_use_held) begin
                r_s2_yaw <= r_held_yaw;
            end else begin
                r_s2_yaw <= r_s1_yaw;
            end
        end
    end

    // stage 3: shifts, sums and limits
    logic signed [63:0] pp_sh, pv_sh, rp_sh, rv_neg, rv_sh, hp_sh, hd_sh;
    logic signed [63:0] i_full, i_sh;
    logic signed [45:0] pitch_sum, roll_sum;
    logic signed [11:0] iterm;
    logic signed [49:0] thrust_raw, thrust_low;
    logic [14:0]        thrust_out;

    assign pp_sh     = r_s2_pp >>> 19;
    assign pv_sh     = r_s2_pv >>> 19;
    assign rp_sh     = r_s2_rp >>> 19;
    assign rv_neg    = -r_s2_rv;
    assign rv_sh     = rv_neg >>> 19;
    assign pitch_sum = $signed(pp_sh[45:0]) + $signed(pv_sh[45:0]);
    assign roll_sum  = $signed(rp_sh[45:0]) + $signed(rv_sh[45:0]);
    assign hp_sh     = r_s2_hp >>> 17;
    assign hd_sh     = r_s2_hd >>> 17;
    assign i_full    = (r_s2_p1 <<< 16) + {{15{r_s2_p0[48]}}, r_s2_p0};
    assign i_sh      = i_full >>> 17;

    // integral term clamped to +-0.05
    always_comb begin
        if (r_s2_p1 > 64'sd1099511627776) begin
            iterm = mphc_pkg::INTEGRAL_LIMIT;
        end else if (r_s2_p1 < -64'sd1099511627776) begin
            iterm = -mphc_pkg::INTEGRAL_LIMIT;
        end else if (i_sh > 64'(mphc_pkg::INTEGRAL_LIMIT)) begin
            iterm = mphc_pkg::INTEGRAL_LIMIT;
        end else if (i_sh < -64'(mphc_pkg::INTEGRAL_LIMIT)) begin
            iterm = -mphc_pkg::INTEGRAL_LIMIT;
        end else begin
            iterm = i_sh[11:0];
        end
    end

    assign thrust_raw = $signed({35'd0, r_thrust_base}) + $signed(hp_sh[49:0])
                      - $signed(hd_sh[49:0]) + {{38{iterm[11]}}, iterm};
    assign thrust_low = (thrust_raw < $signed({35'd0, mphc_pkg::THRUST_FLOOR}))
                      ? $signed({35'd0, mphc_pkg::THRUST_FLOOR}) : thrust_raw;
    assign thrust_out = (thrust_low >= $signed({35'd0, r_s2_ceiling}))
                      ? r_s2_ceiling : thrust_low[14:0];

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_pitch_cmd  <= clamp_angle(pitch_sum);
            o_roll_cmd   <= clamp_angle(roll_sum);
            o_yaw_cmd    <= r_s2_yaw;
            o_thrust_cmd <= thrust_out;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/mphc_checker.sv]
`include "multirotor_position_height_controller_macros.svh"

module mphc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [12:0]               o_roll_cmd,
    input logic signed [12:0]               o_pitch_cmd,
    input logic signed [15:0]               o_yaw_cmd,
    input logic [14:0]                      o_thrust_cmd
);

    // reset empties the pipeline and the skid buffer
    `MPHC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "not empty after reset")

    // a held-up result stays offered
    `MPHC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped under stall")

    // a held-up result does not change
    `MPHC_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_roll_cmd) && $stable(o_pitch_cmd) && $stable(o_yaw_cmd) && $stable(o_thrust_cmd), "result changed under stall")

    // the input side only backs up after the output side was held
    `MPHC_ASSERT(a_stall_cause, $rose(o_in_stall) |-> $past(i_out_stall) && $past(o_out_valid), "input stall without output stall")

    // attitude commands stay within the angle limit
    `MPHC_ASSERT(a_angle_range, o_out_valid |-> o_pitch_cmd <= mphc_pkg::ANGLE_LIMIT && o_pitch_cmd >= -mphc_pkg::ANGLE_LIMIT && o_roll_cmd <= mphc_pkg::ANGLE_LIMIT && o_roll_cmd >= -mphc_pkg::ANGLE_LIMIT, "angle out of range")

endmodule

bind multirotor_position_height_controller mphc_checker u_mphc_checker (.*);
